### hw/rtl/ring_buffer_deque_defines.svh
// Assertion macros used by the deque RTL.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rbd_pkg.sv
// Package: types, field widths, opcodes and status codes of the ring buffer deque.
package rbd_pkg;

    localparam int unsigned DEPTH_DEF      = 1024;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned CHANGE_W = 64;
    localparam int unsigned LIMIT_W  = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // Operation codes; the two remaining codes are ignored.
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE_IDX  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_IDX   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [COUNT_W-1:0]  count;
        logic [CHANGE_W-1:0] change_count;
    } t_out_item;

endpackage

### hw/rtl/rbd_ram.sv
// Generic single-port synchronous RAM with registered read data.
module rbd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // When enabled, write if i_we is set, otherwise register the read; data holds between accesses.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ring_buffer_deque.sv
// Ring buffer deque: a double-ended queue in one synchronous RAM with head and count registers.
// Each transfer carries one operation (push back/front, pop back/front, write or read at a
// logical index) and yields exactly one result transfer. Logical index i sits in slot
// (head + i) mod DEPTH. One operation is taken per clock cycle unless o_in_stall is high; its
// result passes the RAM access stage, registered at the input transfer, then the output register,
// loaded when the output is free or draining. Head, count and change counter are updated at the
// input transfer, so the next operation follows without a gap; a write followed by a read of the
// same slot is safe because the RAM write lands before the next access. The element limit
// register is written through i_cfg_we / i_cfg_wdata; the user must write it only while the
// block is idle, which the block does not enforce. The effective limit is the smaller of that
// register and DEPTH. Slot contents are undefined until written.
module ring_buffer_deque #(
    parameter int unsigned DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rbd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rbd_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rbd_pkg::t_out_item         o_out_item
);

    import rbd_pkg::*;

    `include "ring_buffer_deque_defines.svh"

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned SW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

    // Reduce a sum known to be below twice the depth to a slot number.
    function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
        logic [SW-1:0] diff;
        diff = sum - DEPTH_S;
        return (sum >= DEPTH_S) ? diff[AW-1:0] : sum[AW-1:0];
    endfunction

    // State
    logic [LIMIT_W-1:0]  r_limit;
    logic [AW-1:0]       r_head,    n_head;
    logic [COUNT_W-1:0]  r_held,    n_held;
    logic [CHANGE_W-1:0] r_changes, n_changes;

    // RAM access stage
    logic                r_p1_valid;
    logic [STATUS_W-1:0] r_p1_status;
    logic                r_p1_use_rd;
    logic [COUNT_W-1:0]  r_p1_count;
    logic [CHANGE_W-1:0] r_p1_changes;

    // Output register
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                  in_xfer;
    logic                  p1_move;
    logic                  ram_en;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [63:0]           wide_value;
    logic [63:0]           wide_rdata;
    logic [STATUS_W-1:0]   step_status;
    logic                  step_use_rd;
    logic [SW-1:0]         limit_s;
    logic [SW-1:0]         eff_limit;
    logic [SW-1:0]         held_s;
    logic [SW-1:0]         head_s;
    logic [SW-1:0]         index_s;
    logic                  is_full;
    logic                  is_empty;
    logic                  bad_index;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [COUNT_W-1:0]    held_dec;

    // Handshake: the access stage advances when the output register is free or draining.
    assign p1_move    = r_p1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_p1_valid && r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Conditions on the current state
    assign limit_s   = SW'(r_limit);
    assign eff_limit = (limit_s > DEPTH_S) ? DEPTH_S : limit_s;
    assign held_s    = SW'(r_held);
    assign head_s    = SW'(r_head);
    assign index_s   = SW'(i_in_item.index);
    assign is_full   = held_s >= eff_limit;
    assign is_empty  = (r_held == '0);
    assign bad_index = index_s >= held_s;
    assign head_dec  = (r_head == '0) ? LAST : r_head - AW'(1);
    assign head_inc  = wrap_slot(head_s + SW'(1));
    assign held_dec  = r_held - COUNT_W'(1);

    assign wide_value = 64'(i_in_item.value);
    assign ram_wdata  = wide_value[DATA_WIDTH-1:0];

    // Decode the operation into a RAM access and the next state.
    always_comb begin
        n_head      = r_head;
        n_held      = r_held;
        n_changes   = r_changes;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_head;
        step_status = ST_OK;
        step_use_rd = 1'b0;
        case (i_in_item.op)
            OP_PUSH_BACK: begin
                if (is_full) begin
                    step_status = ST_FULL;
                end else begin
                    ram_en    = 1'b1;
                    ram_we    = 1'b1;
                    ram_addr  = wrap_slot(head_s + held_s);
                    n_held    = r_held + COUNT_W'(1);
                    n_changes = r_changes + CHANGE_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    step_status = ST_FULL;
                end else begin
                    ram_en    = 1'b1;
                    ram_we    = 1'b1;
                    ram_addr  = head_dec;
                    n_head    = head_dec;
                    n_held    = r_held + COUNT_W'(1);
                    n_changes = r_changes + CHANGE_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    step_status = ST_EMPTY;
                end else begin
                    ram_en      = 1'b1;
                    ram_addr    = wrap_slot(head_s + SW'(held_dec));
                    step_use_rd = 1'b1;
                    n_held      = held_dec;
                    n_head      = (held_dec == '0) ? '0 : r_head;
                    n_changes   = r_changes + CHANGE_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    step_status = ST_EMPTY;
                end else begin
                    ram_en      = 1'b1;
                    ram_addr    = r_head;
                    step_use_rd = 1'b1;
                    n_held      = held_dec;
                    n_head      = (held_dec == '0) ? '0 : head_inc;
                    n_changes   = r_changes + CHANGE_W'(1);
                end
            end
            OP_WRITE_IDX: begin
                if (bad_index) begin
                    step_status = ST_BADIDX;
                end else begin
                    ram_en    = 1'b1;
                    ram_we    = 1'b1;
                    ram_addr  = wrap_slot(head_s + index_s);
                    n_changes = r_changes + CHANGE_W'(1);
                end
            end
            OP_READ_IDX: begin
                if (bad_index) begin
                    step_status = ST_BADIDX;
                end else begin
                    ram_en      = 1'b1;
                    ram_addr    = wrap_slot(head_s + index_s);
                    step_use_rd = 1'b1;
                end
            end
            default: begin
                step_status = ST_OK;
            end
        endcase
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_en    (ram_en && in_xfer),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign wide_rdata = 64'(ram_rdata);

    // Hold the element limit; the user must write it only while idle, which is not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Advance head, count and change counter on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_held    <= '0;
            r_changes <= '0;
        end else if (in_xfer) begin
            r_head    <= n_head;
            r_held    <= n_held;
            r_changes <= n_changes;
        end
    end

    // Access stage: track the item whose RAM access is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_p1_valid <= 1'b1;
        end else if (p1_move) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_p1_status  <= step_status;
            r_p1_use_rd  <= step_use_rd;
            r_p1_count   <= n_held;
            r_p1_changes <= n_changes;
        end
    end

    // Output register: load from the access stage, drop on a result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_move) begin
            r_out_item.status       <= r_p1_status;
            r_out_item.data         <= r_p1_use_rd ? wide_rdata[VALUE_W-1:0] : '0;
            r_out_item.count        <= r_p1_count;
            r_out_item.change_count <= r_p1_changes;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `RBD_ASSERT_NOW(a_empty_head_zero, i_clk, i_rst_n, (r_held == '0), (r_head == '0), "head not zero while empty")
    `RBD_ASSERT_NOW(a_stall_needs_p1, i_clk, i_rst_n, o_in_stall, (r_p1_valid && r_out_valid), "input stalled with free stages")
    `RBD_ASSERT_NEXT(a_read_keeps_changes, i_clk, i_rst_n, (in_xfer && (i_in_item.op == OP_READ_IDX)), (r_changes == $past(r_changes)), "read changed the counter")
    `RBD_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, (in_xfer && ((i_in_item.op == OP_PUSH_BACK) || (i_in_item.op == OP_PUSH_FRONT)) && !is_full), (r_held == $past(r_held) + COUNT_W'(1)), "push did not grow the count")

endmodule

### dv/ring_buffer_deque_checker.sv
// Checker for the ring buffer deque: predicts each result and compares it field by field.
module ring_buffer_deque_checker
    import rbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_item,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W = $clog2(DEPTH_DEF);
    localparam int MAX_PRINTED = 100;

    // Shadow copy of the deque and its limit register
    logic [VALUE_W-1:0] slot_mem [DEPTH_DEF];
    logic [PTR_W-1:0]   head;
    logic [COUNT_W-1:0] held;
    logic [CHANGE_W-1:0] changes;
    logic [LIMIT_W-1:0] limit_reg;

    t_out_item results_due [$];
    int mismatches = 0;
    int checked = 0;

    assign o_errors  = mismatches;
    assign o_checked = checked;

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Apply one operation to the shadow deque and return the result it should give
    function automatic t_out_item deque_apply(input t_in_item item);
        t_out_item res;
        logic [COUNT_W-1:0] cap;
        logic [PTR_W-1:0] slot;
        res = '0;
        res.status = ST_OK;
        cap = limit_reg;
        if (cap > DEPTH_DEF) begin
            cap = COUNT_W'(DEPTH_DEF);
        end
        case (item.op)
            OP_PUSH_BACK: begin
                if (held >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    slot = head + held[PTR_W-1:0];
                    slot_mem[slot] = item.value;
                    held++;
                    changes++;
                end
            end
            OP_PUSH_FRONT: begin
                if (held >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    head = head - 1'b1;
                    slot_mem[head] = item.value;
                    held++;
                    changes++;
                end
            end
            OP_POP_BACK: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = head + held[PTR_W-1:0] - 1'b1;
                    res.data = slot_mem[slot];
                    held--;
                    if (held == 0) begin
                        head = '0;
                    end
                    changes++;
                end
            end
            OP_POP_FRONT: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = slot_mem[head];
                    head = head + 1'b1;
                    held--;
                    if (held == 0) begin
                        head = '0;
                    end
                    changes++;
                end
            end
            OP_WRITE_IDX: begin
                if (item.index >= held) begin
                    res.status = ST_BADIDX;
                end else begin
                    slot = head + item.index[PTR_W-1:0];
                    slot_mem[slot] = item.value;
                    changes++;
                end
            end
            OP_READ_IDX: begin
                if (item.index >= held) begin
                    res.status = ST_BADIDX;
                end else begin
                    slot = head + item.index[PTR_W-1:0];
                    res.data = slot_mem[slot];
                end
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
        res.count = held;
        res.change_count = changes;
        return res;
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (results_due.size() == 0) begin
            flag_mismatch($sformatf("result with nothing outstanding: status %0d data %h",
                                    got.status, got.data));
            return;
        end
        want = results_due.pop_front();
        checked++;
        if (got.status !== want.status) begin
            flag_mismatch($sformatf("result %0d status got %0d want %0d",
                                    checked, got.status, want.status));
        end
        if (got.data !== want.data) begin
            flag_mismatch($sformatf("result %0d data got %h want %h",
                                    checked, got.data, want.data));
        end
        if (got.count !== want.count) begin
            flag_mismatch($sformatf("result %0d count got %0d want %0d",
                                    checked, got.count, want.count));
        end
        if (got.change_count !== want.change_count) begin
            flag_mismatch($sformatf("result %0d change_count got %0d want %0d",
                                    checked, got.change_count, want.change_count));
        end
    endtask

    // Track the limit register, check results, then predict new transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head = '0;
            held = '0;
            changes = '0;
            limit_reg = LIMIT_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                limit_reg = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_item);
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(deque_apply(i_in_item));
            end
        end
        o_pending = results_due.size();
    end

endmodule

### dv/ring_buffer_deque_tb.sv
// Testbench top for the ring buffer deque: clock, reset, stimulus, idling and verdict.
module ring_buffer_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
    localparam int HOLD_CYCLES      = 60;
    localparam int DRAIN_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 6;
    localparam int RANDOM_PHASES    = 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_in_item           in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;

    int  errors;
    int  pending;
    int  checked;
    int  items_sent = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;

    always #5 clk = ~clk;

    ring_buffer_deque u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    ring_buffer_deque_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // End the run when no transfer happens on either side for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold when the stimulus asks for one
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one item, idling at random first; returns on the falling edge after the transfer
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
        t_in_item item;
        item.op = op;
        item.value = value;
        item.index = index;
        send_item(item);
    endtask

    // Random operation; most indexes land near the live range set by span
    task automatic send_random(input int span);
        int pick;
        t_in_item item;
        pick = $urandom_range(0, 99);
        item.value = $urandom();
        if ($urandom_range(0, 99) < 85) begin
            item.index = INDEX_W'($urandom_range(0, span));
        end else begin
            item.index = INDEX_W'($urandom_range(0, DEPTH_DEF - 1));
        end
        if (pick < 22) begin
            item.op = OP_PUSH_BACK;
        end else if (pick < 40) begin
            item.op = OP_PUSH_FRONT;
        end else if (pick < 55) begin
            item.op = OP_POP_BACK;
        end else if (pick < 70) begin
            item.op = OP_POP_FRONT;
        end else if (pick < 82) begin
            item.op = OP_WRITE_IDX;
        end else if (pick < 96) begin
            item.op = OP_READ_IDX;
        end else begin
            item.op = pick[0] ? OP_UNUSED_A : OP_UNUSED_B;
        end
        send_item(item);
    endtask

    // Drop valid, hold until every result is back, then keep idling before returning
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [LIMIT_W-1:0] limit;
        int span;

        send_idle_pct = 25;
        stall_pct = 64;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty queue errors, unused codes, extreme values, head wrap on push front
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_READ_IDX, '0, '0);
        send_op(OP_WRITE_IDX, '1, '0);
        send_op(OP_UNUSED_A, '1, '1);
        send_op(OP_UNUSED_B, '1, '1);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF, '1);
        send_op(OP_PUSH_FRONT, 32'h0000_0000, '0);
        send_op(OP_PUSH_BACK, 32'hA5A5_A5A5, '0);
        send_op(OP_READ_IDX, '0, 10'd0);
        send_op(OP_READ_IDX, '0, 10'd1);
        send_op(OP_READ_IDX, '0, 10'd2);
        send_op(OP_READ_IDX, '0, 10'd3);
        send_op(OP_READ_IDX, '0, '1);
        send_op(OP_WRITE_IDX, 32'h5A5A_5A5A, 10'd1);
        send_op(OP_WRITE_IDX, 32'h1111_1111, 10'd3);
        send_op(OP_READ_IDX, '0, 10'd1);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_PUSH_FRONT, 32'h1234_5678, '0);
        send_op(OP_PUSH_BACK, 32'h9ABC_DEF0, '0);
        send_op(OP_READ_IDX, '0, 10'd1);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_FRONT, '0, '0);

        // Limit of zero: every push is refused
        write_limit(11'd0);
        send_op(OP_PUSH_BACK, 32'hDEAD_BEEF, '0);
        send_op(OP_PUSH_FRONT, 32'hDEAD_BEEF, '0);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_WRITE_IDX, 32'hDEAD_BEEF, '0);

        // Limit of one
        write_limit(11'd1);
        send_op(OP_PUSH_BACK, 32'hCAFE_F00D, '0);
        send_op(OP_PUSH_BACK, 32'h0BAD_F00D, '0);
        send_op(OP_PUSH_FRONT, 32'h0BAD_F00D, '0);
        send_op(OP_READ_IDX, '0, '0);
        send_op(OP_POP_BACK, '0, '0);

        // Random mixes under a range of limits and idling profiles
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 2) begin
                send_idle_pct = 64;
                stall_pct = 25;
            end else if (p == 4) begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            case (p)
                0: limit = 11'd3;
                1: limit = 11'd1024;
                2: limit = 11'd2;
                3: limit = 11'd16;
                4: limit = 11'd1;
                default: limit = 11'd2047;
            endcase
            write_limit(limit);
            span = (limit >= 40) ? 40 : limit + 1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i == RANDOM_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_random(span);
            end
        end

        // Limit above depth: fill the whole store, with the output held off at the start
        write_limit(11'd2047);
        hold_request = 1'b1;
        for (int i = 0; i < DEPTH_DEF; i++) begin
            send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom(), '0);
            if (i % 256 == 255) begin
                send_op(OP_READ_IDX, '0, INDEX_W'($urandom_range(0, i)));
            end
        end
        send_op(OP_PUSH_BACK, $urandom(), '0);
        send_op(OP_PUSH_FRONT, $urandom(), '0);
        send_op(OP_READ_IDX, '0, '1);
        send_op(OP_WRITE_IDX, $urandom(), '1);
        send_op(OP_READ_IDX, '0, '1);
        send_op(OP_READ_IDX, '0, 10'd512);
        send_op(OP_WRITE_IDX, $urandom(), '0);
        send_op(OP_READ_IDX, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_FRONT, '0, '0);

        // Pause the sender until everything is back
        wait_drained();
        $display("Summary: %0d operations sent: directed edge cases, random mixes",
                 items_sent);
        $display("Summary: under limits 0 to 2047, three stall profiles, a full-depth fill; %0d checked",
                 checked);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
